FILE: hdl/imsfp_pkg.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser package
// Shared types, byte codes and the frame type lookup.
// ----------------------------------------------------------------------------
package imsfp_pkg;

   // Frame layout
   localparam int FRAME_BYTES = 11;
   localparam logic [3:0] DATA_START = 4'd2;
   localparam logic [3:0] CHECK_POS = 4'(FRAME_BYTES - 1);
   localparam int PAYLOAD_COUNT = FRAME_BYTES - 3;

   // Byte codes
   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [7:0] TYPE_LO = 8'h50;
   localparam logic [7:0] TYPE_HI = 8'h5F;

   localparam logic [7:0] TYPE_TIME = 8'h50;
   localparam logic [7:0] TYPE_ACCEL = 8'h51;
   localparam logic [7:0] TYPE_GYRO = 8'h52;
   localparam logic [7:0] TYPE_ANGLE = 8'h53;
   localparam logic [7:0] TYPE_MAG = 8'h54;
   localparam logic [7:0] TYPE_PRESS = 8'h56;

   // Frame kind codes on the result channel
   localparam logic [2:0] KIND_TIME = 3'd0;
   localparam logic [2:0] KIND_ACCEL = 3'd1;
   localparam logic [2:0] KIND_GYRO = 3'd2;
   localparam logic [2:0] KIND_ANGLE = 3'd3;
   localparam logic [2:0] KIND_MAG = 3'd4;
   localparam logic [2:0] KIND_PRESS = 3'd5;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_TYPE = 2'd1,
      PHASE_DATA = 2'd2
   } phase_type;

   typedef struct packed {
      logic valid;
      logic [7:0] rx_byte;
   } byte_stage_type;

   typedef struct packed {
      logic [2:0] frame_kind;
      logic signed [15:0] word_a;
      logic signed [15:0] word_b;
      logic signed [15:0] word_c;
      logic signed [15:0] word_d;
   } result_type;

   typedef struct packed {
      logic known;
      logic [2:0] kind;
   } kind_lookup_type;

   // Map a frame type byte to its kind; unknown types are flagged
   function automatic kind_lookup_type kind_of_type(input logic [7:0] type_byte);
      kind_lookup_type lookup;
      lookup.known = 1'b1;
      lookup.kind = KIND_TIME;
      unique case (type_byte)
         TYPE_TIME: lookup.kind = KIND_TIME;
         TYPE_ACCEL: lookup.kind = KIND_ACCEL;
         TYPE_GYRO: lookup.kind = KIND_GYRO;
         TYPE_ANGLE: lookup.kind = KIND_ANGLE;
         TYPE_MAG: lookup.kind = KIND_MAG;
         TYPE_PRESS: lookup.kind = KIND_PRESS;
         default: lookup.known = 1'b0;
      endcase
      return lookup;
   endfunction

endpackage

FILE: hdl/imsfp_byte_if.sv
// ----------------------------------------------------------------------------
// Serial byte channel
// Valid/ready channel carrying one received byte per transaction.
// ----------------------------------------------------------------------------
interface imsfp_byte_if;
   logic valid;
   logic ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/imsfp_frame_if.sv
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one decoded frame per transaction.
// ----------------------------------------------------------------------------
interface imsfp_frame_if;
   logic valid;
   logic ready;
   logic [2:0] frame_kind;
   logic signed [15:0] word_a;
   logic signed [15:0] word_b;
   logic signed [15:0] word_c;
   logic signed [15:0] word_d;

   modport source (output valid, output frame_kind, output word_a, output word_b,
                   output word_c, output word_d, input ready);
   modport sink (input valid, input frame_kind, input word_a, input word_b,
                 input word_c, input word_d, output ready);
endinterface

FILE: hdl/imsfp_in_stage.sv
// ----------------------------------------------------------------------------
// IMU frame parser input register
// Captures one byte per transaction and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module imsfp_in_stage
   import imsfp_pkg::*;
(
   input logic clock,
   input logic reset,
   imsfp_byte_if.sink req_chan,
   input logic advance,
   output byte_stage_type byte_out
);

   logic valid_ff;
   logic valid_in;
   logic [7:0] byte_ff;
   logic take;

   // Accept a new byte when empty or when the held byte moves on this cycle
   assign req_chan.ready = !valid_ff || advance;
   assign take = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload
   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= req_chan.rx_byte;
      end
   end

   assign byte_out.valid = valid_ff;
   assign byte_out.rx_byte = byte_ff;

endmodule

FILE: hdl/imsfp_frame_fsm.sv
// ----------------------------------------------------------------------------
// IMU frame parser state machine
// Tracks header, type, payload and checksum of an 11-byte frame and
// produces a decoded frame when the checksum matches a known type.
// ----------------------------------------------------------------------------
module imsfp_frame_fsm
   import imsfp_pkg::*;
(
   input logic clock,
   input logic reset,
   input byte_stage_type byte_in,
   input logic out_free,
   output logic advance,
   output logic load,
   output result_type result
);

   phase_type phase_ff;
   phase_type phase_in;
   logic [3:0] pos_ff;
   logic [3:0] pos_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic [7:0] type_ff;
   logic [7:0] store_ff [PAYLOAD_COUNT];
   logic type_we;
   logic store_we;
   logic emit;
   logic [3:0] slot;
   logic [7:0] b;
   kind_lookup_type lookup;

   assign b = byte_in.rx_byte;
   assign slot = pos_ff - DATA_START;
   assign lookup = kind_of_type(type_ff);

   // Next state and result decision for the held byte
   always_comb begin
      phase_in = phase_ff;
      pos_in = pos_ff;
      sum_in = sum_ff;
      type_we = 1'b0;
      store_we = 1'b0;
      emit = 1'b0;
      unique case (phase_ff)
         PHASE_TYPE: begin
            if (b >= TYPE_LO && b <= TYPE_HI) begin
               type_we = 1'b1;
               sum_in = sum_ff + b;
               pos_in = DATA_START;
               phase_in = PHASE_DATA;
            end else begin
               phase_in = PHASE_HEADER;
            end
         end
         PHASE_DATA: begin
            if (pos_ff >= CHECK_POS) begin
               phase_in = PHASE_HEADER;
               pos_in = '0;
               emit = (b == sum_ff) && lookup.known;
            end else begin
               store_we = 1'b1;
               sum_in = sum_ff + b;
               pos_in = pos_ff + 4'd1;
            end
         end
         default: begin
            // Header search; the unused phase code behaves the same
            phase_in = PHASE_HEADER;
            if (b == HEADER_BYTE) begin
               sum_in = b;
               pos_in = 4'd1;
               phase_in = PHASE_TYPE;
            end
         end
      endcase
   end

   // Hold the byte only when it has a result and the output is full
   assign advance = byte_in.valid && (!emit || out_free);
   assign load = advance && emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HEADER;
         pos_ff <= '0;
         sum_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Frame type and payload storage
   always_ff @(posedge clock) begin
      if (advance && type_we) begin
         type_ff <= b;
      end
      if (advance && store_we) begin
         store_ff[slot[2:0]] <= b;
      end
   end

   // Assemble little-endian words from the stored payload
   assign result.frame_kind = lookup.kind;
   assign result.word_a = {store_ff[1], store_ff[0]};
   assign result.word_b = {store_ff[3], store_ff[2]};
   assign result.word_c = {store_ff[5], store_ff[4]};
   assign result.word_d = {store_ff[7], store_ff[6]};

`ifndef SYNTH
   a_emit_at_check: assert property (@(posedge clock) disable iff (reset)
      load |-> (phase_ff == PHASE_DATA && pos_ff == CHECK_POS))
      else $error("frame result outside checksum position");

   a_data_pos_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PHASE_DATA |-> (pos_ff >= DATA_START && pos_ff <= CHECK_POS))
      else $error("byte position out of range in data phase");

   a_header_to_type: assert property (@(posedge clock) disable iff (reset)
      (advance && phase_ff == PHASE_HEADER && b == HEADER_BYTE)
      |=> (phase_ff == PHASE_TYPE && sum_ff == HEADER_BYTE))
      else $error("header byte did not start a frame");
`endif

endmodule

FILE: hdl/imsfp_out_stage.sv
// ----------------------------------------------------------------------------
// IMU frame parser result register
// Holds one decoded frame until the receiver takes it.
// ----------------------------------------------------------------------------
module imsfp_out_stage
   import imsfp_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic load,
   input result_type result,
   output logic out_free,
   imsfp_frame_if.source rsp_chan
);

   logic valid_ff;
   logic valid_in;
   result_type result_ff;

   // Free when empty or when the held frame leaves this cycle
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.frame_kind = result_ff.frame_kind;
   assign rsp_chan.word_a = result_ff.word_a;
   assign rsp_chan.word_b = result_ff.word_b;
   assign rsp_chan.word_c = result_ff.word_c;
   assign rsp_chan.word_d = result_ff.word_d;

endmodule

FILE: hdl/imu_serial_frame_parser.sv
// ----------------------------------------------------------------------------
// IMU serial frame parser
// Recognizes 11-byte IMU frames in a received byte stream and returns the
// frame kind with four signed 16-bit payload words.
//
// Usage:
//   req_chan carries one received byte per transaction. rsp_chan carries one
//   decoded frame (kind plus words a..d) for each frame whose checksum
//   matches and whose type is time, accel, gyro, angle, magnetic or pressure.
//   Bad type bytes, checksum mismatches and unknown types give no result.
//   Throughput is one byte per cycle while no finished frame waits for a full
//   result register; the byte passes an input register, the parsing logic and
//   the result register. The result is registered in the result register once
//   the checksum byte leaves the input register, and is then valid on rsp_chan.
//   Reset (synchronous) returns the parser to header search and empties both
//   registers; no result is pending afterwards.
//   When the receiver stalls with a result held, bytes that produce no
//   result keep flowing; a byte that completes another frame waits in the
//   input register, and req_chan.ready drops once that register is full.
// ----------------------------------------------------------------------------
module imu_serial_frame_parser
   import imsfp_pkg::*;
(
   input logic clock,
   input logic reset,
   imsfp_byte_if.sink req_chan,
   imsfp_frame_if.source rsp_chan
);

   byte_stage_type byte_stage;
   result_type result;
   logic advance;
   logic load;
   logic out_free;

   imsfp_in_stage u_in_stage (
      .clock (clock),
      .reset (reset),
      .req_chan (req_chan),
      .advance (advance),
      .byte_out (byte_stage)
   );

   imsfp_frame_fsm u_frame_fsm (
      .clock (clock),
      .reset (reset),
      .byte_in (byte_stage),
      .out_free (out_free),
      .advance (advance),
      .load (load),
      .result (result)
   );

   imsfp_out_stage u_out_stage (
      .clock (clock),
      .reset (reset),
      .load (load),
      .result (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule
